FILE: rtl/lsf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsf_pkg: shared definitions for the line substring filter
// Sizes, register indexes, mode codes and the types passed between modules.
// ----------------------------------------------------------------------------
package lsf_pkg;

	localparam int PATTERN_BYTES = 16;
	localparam int CHUNK_LIMIT   = 255;
	localparam int FILL_W        = $clog2(CHUNK_LIMIT + 1);
	localparam int LEN_W         = $clog2(PATTERN_BYTES + 1);
	localparam int WIN_IDX_W     = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
	localparam int REG_INDEX_W   = 8;
	localparam int REG_DATA_W    = 64;
	localparam int STORED_BYTES  = 16;

	typedef logic [7:0] char_t;
	typedef char_t [PATTERN_BYTES-1:0] window_t;

	localparam char_t CHAR_NUL     = 8'h00;
	localparam char_t CHAR_NEWLINE = 8'h0A;

	// Register indexes on the configuration port
	localparam logic [REG_INDEX_W-1:0] REG_MODE         = REG_INDEX_W'(0);
	localparam logic [REG_INDEX_W-1:0] REG_PATTERN_LEN  = REG_INDEX_W'(1);
	localparam logic [REG_INDEX_W-1:0] REG_PATTERN_LOW  = REG_INDEX_W'(2);
	localparam logic [REG_INDEX_W-1:0] REG_PATTERN_HIGH = REG_INDEX_W'(3);

	typedef enum logic [2:0] {
		MODE_MATCH  = 3'd0,
		MODE_FOLD   = 3'd1,
		MODE_INVERT = 3'd2,
		MODE_NUMBER = 3'd3,
		MODE_COUNT  = 3'd4
	} mode_t;

	// Window compare request from the chunk logic to the matcher
	typedef struct packed {
		window_t              window;
		window_t              pattern;
		logic [LEN_W-1:0]     len;
		logic                 folding;
	} match_req_t;

endpackage
`default_nettype wire

FILE: rtl/lsf_item_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsf_item_if: input item channel
// One file byte or a bare end marker per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lsf_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_file;

	modport source(output valid, output data_byte, output has_byte, output end_of_file,
		input ready);
	modport sink(input valid, input data_byte, input has_byte, input end_of_file,
		output ready);
endinterface
`default_nettype wire

FILE: rtl/lsf_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsf_result_if: result item channel
// One result per closed chunk or end of file, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lsf_result_if;
	logic        valid;
	logic        ready;
	logic        line_done;
	logic        line_selected;
	logic [31:0] line_index;
	logic [31:0] match_total;
	logic        stream_done;

	modport source(output valid, output line_done, output line_selected,
		output line_index, output match_total, output stream_done, input ready);
	modport sink(input valid, input line_done, input line_selected,
		input line_index, input match_total, input stream_done, output ready);
endinterface
`default_nettype wire

FILE: rtl/lsf_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsf_cfg_if: configuration write channel
// Register index and write data, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lsf_cfg_if import lsf_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [REG_INDEX_W-1:0] index;
	logic [REG_DATA_W-1:0]  data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/lsf_matcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsf_matcher: parallel window compare
// Compares the newest len window bytes against the pattern in one pass,
// with optional ASCII case folding on both sides.
// ----------------------------------------------------------------------------
module lsf_matcher import lsf_pkg::*; (
	input  match_req_t req,
	output logic       hit
);

	function automatic char_t fold(input char_t c, input logic on);
		if (on && c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'h20;
		end
		return c;
	endfunction

	logic [PATTERN_BYTES-1:0] byte_eq;

	// Pattern byte i lines up with the window byte len-1-i places back
	always_comb begin
		logic [LEN_W-1:0] pos;
		for (int i = 0; i < PATTERN_BYTES; i++) begin
			pos = req.len - LEN_W'(1) - LEN_W'(i);
			if (LEN_W'(i) >= req.len) begin
				byte_eq[i] = 1'b1;
			end else begin
				byte_eq[i] = fold(req.window[pos[WIN_IDX_W-1:0]], req.folding)
					== fold(req.pattern[i], req.folding);
			end
		end
	end

	assign hit = &byte_eq;

endmodule
`default_nettype wire

FILE: rtl/line_substring_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_substring_filter: fixed-string line grep over a byte stream
// Splits the text into line chunks and reports per chunk whether it holds
// the configured pattern, with line numbers and a running match count.
// ----------------------------------------------------------------------------
// Usage:
//   items   : one file byte per item (has_byte), end_of_file on the last item;
//             a bare item with neither flag gives no result.
//   results : one item per closed chunk (newline or 255 bytes) and one on the
//             end-of-file item, which carries the final match_total.
//   cfg     : register writes (mode, pattern_length, pattern_low/high), always
//             ready; write only while no item is in flight.
// Timing: an accepted item waits in the input register until it can advance,
//   and its result is then loaded into the result register.
// Throughput: one item per cycle unless stalled; the window compare and chunk
//   update are one combinational pass between the input and result registers.
// Stalls: a waiting result holds; the input register keeps taking an item
//   in the same cycle the result is taken, and holds when the result is stuck.
// Reset: clears the config, chunk state, counters and valid flags to zero.
// ----------------------------------------------------------------------------
module line_substring_filter import lsf_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	lsf_item_if.sink    items,
	lsf_result_if.source results,
	lsf_cfg_if.sink     cfg
);

	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	// Configuration registers
	logic [2:0]           mode_q;
	logic [4:0]           pattern_len_q;
	logic [63:0]          pattern_low_q;
	logic [63:0]          pattern_high_q;
	logic [LEN_W-1:0]     eff_len_q;

	// Chunk and file state
	window_t              window_q;
	logic [FILL_W-1:0]    fill_q;
	logic                 matched_q;
	logic                 nul_q;
	logic [31:0]          line_q;
	logic [31:0]          match_q;

	// Input register
	logic                 valid_s1;
	char_t                data_byte_s1;
	logic                 has_byte_s1;
	logic                 end_of_file_s1;

	// Result register
	logic                 out_valid_q;
	logic                 line_done_q;
	logic                 line_selected_q;
	logic [31:0]          line_index_q;
	logic [31:0]          match_total_q;
	logic                 stream_done_q;

	logic                 advance;
	window_t              pattern;
	logic [LEN_W-1:0]     eff_len_d;
	match_req_t           req;
	logic                 window_hit;

	assign cfg.ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= '0;
			pattern_len_q  <= '0;
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MODE:         mode_q         <= cfg.data[2:0];
				REG_PATTERN_LEN:  pattern_len_q  <= cfg.data[4:0];
				REG_PATTERN_LOW:  pattern_low_q  <= cfg.data;
				REG_PATTERN_HIGH: pattern_high_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Unpack pattern bytes; bytes beyond the stored ones read as NUL
	always_comb begin
		logic [8*STORED_BYTES-1:0] flat;
		flat = {pattern_high_q, pattern_low_q};
		for (int i = 0; i < PATTERN_BYTES; i++) begin
			if (i < STORED_BYTES) begin
				pattern[i] = flat[8*(i % STORED_BYTES) +: 8];
			end else begin
				pattern[i] = CHAR_NUL;
			end
		end
	end

	// Effective length: clamp, then stop before the first NUL pattern byte
	always_comb begin
		logic [LEN_W-1:0] lim;
		if (32'(pattern_len_q) > 32'(PATTERN_BYTES)) begin
			lim = LEN_W'(PATTERN_BYTES);
		end else begin
			lim = LEN_W'(pattern_len_q);
		end
		eff_len_d = lim;
		for (int i = PATTERN_BYTES - 1; i >= 0; i--) begin
			if (LEN_W'(i) < lim && pattern[i] == CHAR_NUL) begin
				eff_len_d = LEN_W'(i);
			end
		end
	end

	// Hold the effective length; config settles before an item reaches it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_len_q <= '0;
		end else begin
			eff_len_q <= eff_len_d;
		end
	end

	// Advance the input register when the result register can take it
	assign advance     = valid_s1 && (!out_valid_q || results.ready);
	assign items.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			data_byte_s1   <= items.data_byte;
			has_byte_s1    <= items.has_byte;
			end_of_file_s1 <= items.end_of_file;
		end
	end

	// Chunk step: shift window, compare, count
	logic                 nul_d;
	logic                 shift_in;
	window_t              window_sh;
	logic [FILL_W-1:0]    fill_d;
	logic                 long_enough;
	logic                 matched_d;
	logic                 close;
	logic                 hit;
	logic                 selected;
	logic [31:0]          line_d;
	logic [31:0]          match_d;
	logic                 emit;

	always_comb begin
		window_sh[0] = data_byte_s1;
		for (int k = 1; k < PATTERN_BYTES; k++) begin
			window_sh[k] = window_q[k-1];
		end
	end

	assign req.window  = window_sh;
	assign req.pattern = pattern;
	assign req.len     = eff_len_q;
	assign req.folding = (mode_q == MODE_FOLD);

	lsf_matcher u_matcher (
		.req (req),
		.hit (window_hit)
	);

	always_comb begin
		nul_d       = nul_q || (has_byte_s1 && data_byte_s1 == CHAR_NUL);
		shift_in    = has_byte_s1 && !nul_d;
		long_enough = ((FILL_W+1)'(fill_q) + (FILL_W+1)'(1)) >= (FILL_W+1)'(eff_len_q);
		matched_d   = matched_q
			|| (shift_in && eff_len_q != '0 && long_enough && window_hit);

		fill_d = fill_q;
		if (has_byte_s1 && 32'(fill_q) < 32'(CHUNK_LIMIT)) begin
			fill_d = fill_q + FILL_W'(1);
		end

		close = (has_byte_s1
				&& (data_byte_s1 == CHAR_NEWLINE || 32'(fill_d) >= 32'(CHUNK_LIMIT)))
			|| (end_of_file_s1 && fill_d != '0);
		hit   = matched_d || eff_len_q == '0;

		line_d  = line_q;
		match_d = match_q;
		if (close && line_q != COUNT_MAX) begin
			line_d = line_q + 32'd1;
		end
		if (close && hit && match_q != COUNT_MAX) begin
			match_d = match_q + 32'd1;
		end

		// Mode decode; unused codes behave as plain match
		case (mode_q)
			MODE_INVERT: selected = close && !hit;
			MODE_COUNT:  selected = 1'b0;
			default:     selected = close && hit;
		endcase

		emit = close || end_of_file_s1;
	end

	// Update chunk state and counters; clear at chunk close and end of file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= '0;
			fill_q    <= '0;
			matched_q <= 1'b0;
			nul_q     <= 1'b0;
			line_q    <= '0;
			match_q   <= '0;
		end else if (advance) begin
			if (emit) begin
				window_q  <= '0;
				fill_q    <= '0;
				matched_q <= 1'b0;
				nul_q     <= 1'b0;
			end else begin
				if (shift_in) begin
					window_q <= window_sh;
				end
				fill_q    <= fill_d;
				matched_q <= matched_d;
				nul_q     <= nul_d;
			end
			if (end_of_file_s1) begin
				line_q  <= '0;
				match_q <= '0;
			end else begin
				line_q  <= line_d;
				match_q <= match_d;
			end
		end
	end

	// Result register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			line_done_q     <= close;
			line_selected_q <= selected;
			line_index_q    <= close ? line_d : 32'd0;
			match_total_q   <= match_d;
			stream_done_q   <= end_of_file_s1;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.line_done     = line_done_q;
	assign results.line_selected = line_selected_q;
	assign results.line_index    = line_index_q;
	assign results.match_total   = match_total_q;
	assign results.stream_done   = stream_done_q;

endmodule
`default_nettype wire

FILE: tb/sv/lsf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsf_checker: line report predictor and scoreboard for line_substring_filter
// Watches the item, result and configuration channels. It keeps its own copy
// of the registers and chunk state, predicts one line report per accepted
// item that closes a chunk or ends a file, and compares each result with
// the oldest pending prediction.
// ----------------------------------------------------------------------------
module lsf_checker import lsf_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	lsf_item_if   items,
	lsf_result_if results,
	lsf_cfg_if    cfg,
	output int    fail_count,
	output int    pending,
	output int    checked,
	output int    selected
);

	typedef struct packed {
		bit        line_done;
		bit        line_selected;
		bit [31:0] line_index;
		bit [31:0] match_total;
		bit        stream_done;
	} line_report_t;

	line_report_t reports_due[$];

	// Shadow registers
	logic [2:0]  mode_reg;
	logic [4:0]  pat_len_reg;
	logic [63:0] pat_low_reg;
	logic [63:0] pat_high_reg;

	// Shadow chunk state, newest byte at entry 0
	char_t       recent[PATTERN_BYTES];
	int unsigned fill;
	bit          hit_in_chunk;
	bit          nul_in_chunk;
	bit [31:0]   line_count;
	bit [31:0]   match_count;

	function automatic char_t pattern_byte(input int unsigned i);
		if (i < 8)
			return pat_low_reg[8*i +: 8];
		if (i < 16)
			return pat_high_reg[8*(i-8) +: 8];
		return CHAR_NUL;
	endfunction

	// Usable pattern length: clamp to the window, stop at the first NUL
	function automatic int unsigned pattern_span();
		int unsigned lim;
		int unsigned i;
		lim = (pat_len_reg > PATTERN_BYTES) ? PATTERN_BYTES : pat_len_reg;
		for (i = 0; i < lim; i++)
			if (pattern_byte(i) == CHAR_NUL)
				return i;
		return lim;
	endfunction

	function automatic char_t fold_case(input char_t c, input bit on);
		if (on && c >= "A" && c <= "Z")
			return c + 8'h20;
		return c;
	endfunction

	function automatic void clear_chunk();
		int k;
		for (k = 0; k < PATTERN_BYTES; k++)
			recent[k] = CHAR_NUL;
		fill = 0;
		hit_in_chunk = 1'b0;
		nul_in_chunk = 1'b0;
	endfunction

	// Advance the shadow state by one item; return 1 if it yields a report
	function automatic bit predict_line(input char_t b, input bit has, input bit eof,
		output line_report_t rep);
		mode_t       eff_mode;
		bit          folding;
		bit          close;
		bit          hit;
		bit          same;
		int unsigned plen;
		int unsigned i;
		int          k;
		eff_mode = (mode_reg > 3'(MODE_COUNT)) ? MODE_MATCH : mode_t'(mode_reg);
		folding = (eff_mode == MODE_FOLD);
		plen = pattern_span();
		close = 1'b0;
		rep = '0;
		if (!has && !eof)
			return 1'b0;

		if (has) begin
			if (b == CHAR_NUL)
				nul_in_chunk = 1'b1;
			// Bytes from a NUL on take no part in matching
			if (!nul_in_chunk) begin
				for (k = PATTERN_BYTES - 1; k > 0; k--)
					recent[k] = recent[k-1];
				recent[0] = b;
				if (plen > 0 && fill + 1 >= plen) begin
					same = 1'b1;
					for (i = 0; i < plen; i++)
						if (fold_case(recent[plen-1-i], folding) !=
							fold_case(pattern_byte(i), folding))
							same = 1'b0;
					if (same)
						hit_in_chunk = 1'b1;
				end
			end
			if (fill < CHUNK_LIMIT)
				fill++;
			if (b == CHAR_NEWLINE || fill >= CHUNK_LIMIT)
				close = 1'b1;
		end
		if (eof && fill > 0)
			close = 1'b1;

		// Close the chunk: count it and decide whether it is selected
		if (close) begin
			hit = hit_in_chunk || plen == 0;
			if (line_count != '1)
				line_count++;
			if (hit && match_count != '1)
				match_count++;
			rep.line_done = 1'b1;
			rep.line_index = line_count;
			case (eff_mode)
				MODE_INVERT: rep.line_selected = !hit;
				MODE_COUNT:  rep.line_selected = 1'b0;
				default:     rep.line_selected = hit;
			endcase
			clear_chunk();
		end
		rep.match_total = match_count;
		rep.stream_done = eof;

		// A new file starts after the end marker
		if (eof) begin
			clear_chunk();
			line_count = '0;
			match_count = '0;
		end
		return close || eof;
	endfunction

	function automatic void check_field(input string name, input bit [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : scoreboard
		line_report_t want;
		line_report_t next_rep;
		if (!arst_n) begin
			mode_reg = 3'(MODE_MATCH);
			pat_len_reg = '0;
			pat_low_reg = '0;
			pat_high_reg = '0;
			clear_chunk();
			line_count = '0;
			match_count = '0;
			reports_due.delete();
		end else begin
			// Compare a taken result with the oldest prediction
			if (results.valid && results.ready) begin
				if (reports_due.size() == 0) begin
					$error("result with no line report pending");
					fail_count++;
				end else begin
					want = reports_due.pop_front();
					check_field("line_done", 32'(want.line_done), 32'(results.line_done));
					check_field("line_selected", 32'(want.line_selected),
						32'(results.line_selected));
					check_field("line_index", want.line_index, results.line_index);
					check_field("match_total", want.match_total, results.match_total);
					check_field("stream_done", 32'(want.stream_done),
						32'(results.stream_done));
					checked++;
					if (results.line_selected === 1'b1)
						selected++;
				end
			end

			// Track register writes
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_MODE:         mode_reg = cfg.data[2:0];
					REG_PATTERN_LEN:  pat_len_reg = cfg.data[4:0];
					REG_PATTERN_LOW:  pat_low_reg = cfg.data;
					REG_PATTERN_HIGH: pat_high_reg = cfg.data;
					default: ;
				endcase
			end

			// Predict from each taken item
			if (items.valid && items.ready) begin
				if (predict_line(items.data_byte, items.has_byte, items.end_of_file, next_rep))
					reports_due.push_back(next_rep);
			end
		end
		pending = reports_due.size();
	end

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: testbench for line_substring_filter
// Drives directed and random text files through the block under changing
// filter settings, with random gaps and result stalls, and reports the
// verdict from the scoreboard's failure count.
// ----------------------------------------------------------------------------
module tb_top;
	import lsf_pkg::*;

	localparam int         ITEM_GOAL    = 1850;
	localparam int         QUIET_TAIL   = 150;
	localparam int         DRAIN_CYCLES = 4;
	localparam logic [2:0] MODE_SPARE   = 3'd7;

	logic clk;
	logic arst_n;

	lsf_item_if   items();
	lsf_result_if results();
	lsf_cfg_if    cfg();

	int fail_count;
	int pending;
	int checked;
	int selected;

	bit tx_gaps;
	bit rx_stalls;
	int items_sent;
	int files_sent;
	int settings_used;

	// Pattern as currently configured, for building text that hits it
	char_t pat[PATTERN_BYTES];
	int    pat_n;

	line_substring_filter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results),
		.cfg     (cfg)
	);

	lsf_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.results    (results),
		.cfg        (cfg),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked),
		.selected   (selected)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the result side in random bursts while rx_stalls is set
	initial begin
		int hold;
		hold = 0;
		results.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				results.ready <= 1'b0;
			end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(0, 5);
				results.ready <= 1'b0;
			end else begin
				results.ready <= 1'b1;
			end
		end
	end

	initial begin
		#3_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Send one item, with an optional gap before it; return at a falling edge
	task automatic push_item(input char_t b, input bit has, input bit eof);
		int gap;
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			items.valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(negedge clk);
		end
		items.valid <= 1'b1;
		items.data_byte <= b;
		items.has_byte <= has;
		items.end_of_file <= eof;
		@(posedge clk);
		while (!items.ready)
			@(posedge clk);
		@(negedge clk);
		if (has || eof)
			items_sent++;
		if (eof)
			files_sent++;
		// No idling in the last part of the run
		if (items_sent >= ITEM_GOAL - QUIET_TAIL) begin
			tx_gaps = 1'b0;
			rx_stalls = 1'b0;
		end
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			push_item(s[i], 1'b1, 1'b0);
	endtask

	// Hold off until every report is back and the pipeline is empty
	task automatic settle();
		items.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Write all four registers back to back and note the usable pattern
	task automatic cfg_set(input logic [2:0] m, input logic [4:0] n,
		input logic [63:0] lo, input logic [63:0] hi);
		logic [REG_INDEX_W-1:0] idx[4];
		logic [63:0]            val[4];
		int                     r;
		int                     lim;
		idx = '{REG_MODE, REG_PATTERN_LEN, REG_PATTERN_LOW, REG_PATTERN_HIGH};
		val = '{64'(m), 64'(n), lo, hi};
		for (r = 0; r < 4; r++) begin
			cfg.valid <= 1'b1;
			cfg.index <= idx[r];
			cfg.data <= val[r];
			@(posedge clk);
			while (!cfg.ready)
				@(posedge clk);
			@(negedge clk);
		end
		cfg.valid <= 1'b0;
		settings_used++;
		for (r = 0; r < PATTERN_BYTES; r++)
			pat[r] = (r < 8) ? lo[8*r +: 8] : hi[8*(r-8) +: 8];
		lim = (n > PATTERN_BYTES) ? PATTERN_BYTES : n;
		pat_n = lim;
		for (r = lim - 1; r >= 0; r--)
			if (pat[r] == CHAR_NUL)
				pat_n = r;
	endtask

	function automatic char_t pick_letter();
		string alph;
		alph = "abcABC";
		return alph[$urandom_range(0, 5)];
	endfunction

	function automatic char_t flip_case(input char_t c);
		if ((c | 8'h20) >= "a" && (c | 8'h20) <= "z")
			return c ^ 8'h20;
		return c;
	endfunction

	// Mostly pattern bytes and letters, some arbitrary bytes and NULs
	function automatic char_t text_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45 && pat_n > 0)
			return pat[$urandom_range(0, pat_n - 1)];
		if (r < 80)
			return pick_letter();
		if (r < 97)
			return char_t'($urandom_range(1, 255));
		return CHAR_NUL;
	endfunction

	// Send one line of text, sometimes with the whole pattern inside it
	task automatic send_line();
		int n;
		int at;
		int i;
		int j;
		bit flip;
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(240, 300) : $urandom_range(0, 12);
		at = (pat_n > 0 && $urandom_range(0, 2) == 0) ? $urandom_range(0, n) : -1;
		flip = ($urandom_range(0, 3) == 0);
		for (i = 0; i <= n; i++) begin
			if (i == at)
				for (j = 0; j < pat_n; j++)
					push_item(flip ? flip_case(pat[j]) : pat[j], 1'b1, 1'b0);
			if ($urandom_range(0, 29) == 0)
				push_item(char_t'($urandom_range(0, 255)), 1'b0, 1'b0);
			if (i < n)
				push_item(text_byte(), 1'b1, 1'b0);
		end
		if ($urandom_range(0, 9) != 0)
			push_item(CHAR_NEWLINE, 1'b1, 1'b0);
	endtask

	initial begin
		logic [2:0]  m;
		logic [4:0]  n;
		logic [63:0] lo;
		logic [63:0] hi;
		char_t       pb[PATTERN_BYTES];
		int          lines;
		int          i;

		arst_n = 1'b0;
		items.valid = 1'b0;
		items.data_byte = '0;
		items.has_byte = 1'b0;
		items.end_of_file = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
		items_sent = 0;
		files_sent = 0;
		settings_used = 0;
		pat_n = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Plain match, a NUL that hides the pattern, an ignored bare item,
		// and an end marker on an empty chunk
		cfg_set(MODE_MATCH, 5'd2, 64'h6261, 64'h0);
		send_text("xab\n");
		push_item(CHAR_NUL, 1'b1, 1'b0);
		send_text("ab\n");
		push_item(8'hFF, 1'b0, 1'b0);
		push_item(8'hFF, 1'b0, 1'b1);
		settle();

		// Case-folded match on both sides, end marker closing a chunk
		cfg_set(MODE_FOLD, 5'd2, 64'h4261, 64'h0);
		push_item(8'hFF, 1'b1, 1'b0);
		send_text("xA");
		push_item("b", 1'b1, 1'b1);
		settle();

		// Empty pattern inverted: every line holds it, none is selected
		cfg_set(MODE_INVERT, 5'd0, '1, '1);
		send_text("z\n");
		push_item(CHAR_NUL, 1'b0, 1'b1);
		settle();

		// Spare mode, overlong length, pattern cut short by a NUL
		cfg_set(MODE_SPARE, 5'd31, 64'h0000_0000_0000_6362, '1);
		send_text("abc\n");
		push_item(CHAR_NUL, 1'b0, 1'b1);
		settle();

		// Line numbers, then count only
		cfg_set(MODE_NUMBER, 5'd1, 64'h63, 64'h0);
		send_text("c\n");
		settle();
		cfg_set(MODE_COUNT, 5'd1, 64'h63, 64'h0);
		push_item("c", 1'b1, 1'b1);
		settle();

		// Random files under random settings; some files run on across a
		// settings change
		while (items_sent < ITEM_GOAL) begin
			if (items_sent >= ITEM_GOAL - QUIET_TAIL) begin
				tx_gaps = 1'b0;
				rx_stalls = 1'b0;
			end else begin
				tx_gaps = ($urandom_range(0, 3) != 0);
				rx_stalls = ($urandom_range(0, 3) != 0);
			end
			settle();

			m = 3'($urandom_range(0, 7));
			case ($urandom_range(0, 9))
				0:       n = 5'd0;
				1:       n = 5'($urandom_range(17, 31));
				2:       n = 5'd16;
				default: n = 5'($urandom_range(1, 4));
			endcase
			for (i = 0; i < PATTERN_BYTES; i++)
				pb[i] = ($urandom_range(0, 19) == 0) ? CHAR_NEWLINE : pick_letter();
			if ($urandom_range(0, 7) == 0)
				pb[$urandom_range(0, PATTERN_BYTES - 1)] = CHAR_NUL;
			for (i = 0; i < 8; i++) begin
				lo[8*i +: 8] = pb[i];
				hi[8*i +: 8] = pb[i+8];
			end
			case ($urandom_range(0, 9))
				0: begin
					lo = {$urandom, $urandom};
					hi = {$urandom, $urandom};
				end
				1: begin
					lo = '1;
					hi = '1;
				end
				2: begin
					lo = '0;
					hi = '0;
				end
				default: ;
			endcase
			cfg_set(m, n, lo, hi);

			lines = $urandom_range(1, 8);
			for (i = 0; i < lines; i++)
				send_line();

			// End the file in one of several ways, or leave it open
			case ($urandom_range(0, 7))
				0, 1, 2: push_item(char_t'($urandom_range(0, 255)), 1'b0, 1'b1);
				3, 4:    push_item(text_byte(), 1'b1, 1'b1);
				5: begin
					push_item(CHAR_NEWLINE, 1'b0, 1'b1);
					push_item(CHAR_NUL, 1'b0, 1'b1);
				end
				default: ;
			endcase
		end

		tx_gaps = 1'b0;
		rx_stalls = 1'b0;
		settle();

		$display("Ran %0d items in %0d files under %0d filter settings.",
			items_sent, files_sent, settings_used);
		$display("Compared %0d line reports, %0d of them for selected lines.",
			checked, selected);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire
